// ===== rtl/positional_list_engine_top_assert.svh =====
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Check that cons holds in every cycle in which ante holds.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Check that cons holds in the cycle after ante holds.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int ST_W     = 2;
    localparam int TOT_W    = 7;
    localparam int CMP_W    = POS_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_DUMP      = 3'd6,
        CMD_NOP       = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_BACK,
        S_FIX,
        S_DUMP,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        OP_RESP,
        OP_INS_EMPTY,
        OP_INS_FRONT,
        OP_INS_BACK,
        OP_INS_MID,
        OP_DEL_ONLY,
        OP_DEL_FRONT,
        OP_DEL_BACK,
        OP_DEL_MID,
        OP_DUMP
    } t_op;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } t_link_req;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
    } t_val_req;

    typedef struct packed {
        logic             alloc_en;
        logic [IDX_W-1:0] alloc_idx;
        logic             release_en;
        logic [IDX_W-1:0] release_idx;
    } t_free_ctl;

endpackage

// ===== rtl/ple_ram.sv =====
`timescale 1ns / 1ps

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word, read one word; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ple_free_map.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_top_assert.svh"

module ple_free_map
    import ple_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_free_ctl        i_ctl,
    output logic [IDX_W-1:0] o_alloc_slot
);

    logic [CAPACITY-1:0] r_free;
    logic [CAPACITY-1:0] n_free;
    logic [CAPACITY-1:0] lowest;
    logic [IDX_W-1:0]    r_alloc;
    logic [IDX_W-1:0]    n_alloc;

    // Mark a slot taken on allocation, free on release
    always_comb begin
        n_free = r_free;
        if (i_ctl.alloc_en) begin
            n_free[i_ctl.alloc_idx] = 1'b0;
        end
        if (i_ctl.release_en) begin
            n_free[i_ctl.release_idx] = 1'b1;
        end
    end

    // Isolate the lowest free bit, then encode its index
    always_comb begin
        lowest  = r_free & (~r_free + CAPACITY'(1));
        n_alloc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lowest[i]) begin
                n_alloc = n_alloc | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '1;
            r_alloc <= '0;
        end else begin
            r_free  <= n_free;
            r_alloc <= n_alloc;
        end
    end

    assign o_alloc_slot = r_alloc;

    `PLE_ASSERT_NOW(a_alloc_was_free, i_clk, i_rst_n, i_ctl.alloc_en, r_free[i_ctl.alloc_idx])
    `PLE_ASSERT_NOW(a_release_was_used, i_clk, i_rst_n, i_ctl.release_en, !r_free[i_ctl.release_idx])
    `PLE_ASSERT_NOW(a_one_change, i_clk, i_rst_n, i_ctl.alloc_en, !i_ctl.release_en)

endmodule

// ===== rtl/ple_seq.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_top_assert.svh"

module ple_seq
    import ple_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [TOT_W-1:0]        o_element_total,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_last_item,
    output t_val_req                o_val_req,
    input  logic [VAL_W-1:0]        i_val_rd_data,
    output t_link_req               o_fwd_req,
    input  logic [IDX_W-1:0]        i_fwd_rd_data,
    output t_link_req               o_bwd_req,
    input  logic [IDX_W-1:0]        i_bwd_rd_data,
    output t_free_ctl               o_free_ctl,
    input  logic [IDX_W-1:0]        i_alloc_slot
);

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [VAL_W-1:0]   r_val;
    logic [POS_W-1:0]   r_pos;
    t_op                r_op, n_op;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [IDX_W-1:0]   r_nbr, n_nbr;
    logic [CNT_W-1:0]   r_left, n_left;

    logic               r_out_valid;
    t_status            r_o_status, n_o_status;
    logic [TOT_W-1:0]   r_o_total, n_o_total;
    logic [VAL_W-1:0]   r_o_value, n_o_value;
    logic               r_o_last, n_o_last;
    logic               out_load;
    logic               out_free;

    logic [CMP_W-1:0]   cnt_c;
    logic [CMP_W-1:0]   cnt_p1;
    logic [CMP_W-1:0]   pos_c;
    logic [CMP_W-1:0]   ins_pos;
    logic [CMP_W-1:0]   del_pos;
    t_op                op;
    t_status            op_status;
    logic               walk_done;
    logic               walking;
    logic               resp_leave;
    logic               resp_loaded;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign walk_done  = (r_left == CNT_W'(1));

    // Decode the held request against the current count
    always_comb begin
        cnt_c     = CMP_W'(r_count);
        cnt_p1    = cnt_c + CMP_W'(1);
        pos_c     = CMP_W'(r_pos);
        op        = OP_RESP;
        op_status = ST_OK;
        ins_pos   = pos_c;
        del_pos   = pos_c;
        if (r_cmd == CMD_INS_FIRST) begin
            ins_pos = CMP_W'(1);
        end else if (r_cmd == CMD_INS_LAST) begin
            ins_pos = cnt_p1;
        end
        if (r_cmd == CMD_DEL_FIRST) begin
            del_pos = CMP_W'(1);
        end else if (r_cmd == CMD_DEL_LAST) begin
            del_pos = cnt_c;
        end
        unique case (r_cmd) inside
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
                if (ins_pos == '0 || ins_pos > cnt_p1) begin
                    op_status = ST_BADPOS;
                end else if (cnt_c == CMP_W'(CAPACITY)) begin
                    op_status = ST_FULL;
                end else if (cnt_c == '0) begin
                    op = OP_INS_EMPTY;
                end else if (ins_pos == CMP_W'(1)) begin
                    op = OP_INS_FRONT;
                end else if (ins_pos == cnt_p1) begin
                    op = OP_INS_BACK;
                end else begin
                    op = OP_INS_MID;
                end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
                if (r_cmd != CMD_DEL_POS && cnt_c == '0) begin
                    op_status = ST_EMPTY;
                end else if (del_pos == '0 || del_pos > cnt_c) begin
                    op_status = ST_BADPOS;
                end else if (cnt_c == CMP_W'(1)) begin
                    op = OP_DEL_ONLY;
                end else if (del_pos == CMP_W'(1)) begin
                    op = OP_DEL_FRONT;
                end else if (del_pos == cnt_c) begin
                    op = OP_DEL_BACK;
                end else begin
                    op = OP_DEL_MID;
                end
            end
            CMD_DUMP: begin
                if (cnt_c == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    op = OP_DUMP;
                end
            end
            default: begin
                op_status = ST_OK;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (op) inside
                    OP_INS_MID, OP_DEL_FRONT, OP_DEL_MID: n_state = S_WALK;
                    OP_DEL_BACK:                           n_state = S_BACK;
                    OP_DUMP:                               n_state = S_DUMP;
                    default:                               n_state = S_RESP;
                endcase
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = (r_op == OP_INS_MID) ? S_FIX : S_RESP;
                end
            end
            S_BACK: n_state = S_RESP;
            S_FIX:  n_state = S_RESP;
            S_DUMP: begin
                if (out_free && walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory requests, list pointers and result loading
    always_comb begin
        n_op       = r_op;
        n_status   = r_status;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_slot     = r_slot;
        n_ptr      = r_ptr;
        n_prev     = r_prev;
        n_nbr      = r_nbr;
        n_left     = r_left;
        o_val_req  = '0;
        o_fwd_req  = '0;
        o_bwd_req  = '0;
        o_free_ctl = '0;
        out_load   = 1'b0;
        n_o_status = r_o_status;
        n_o_total  = r_o_total;
        n_o_value  = r_o_value;
        n_o_last   = r_o_last;
        unique case (r_state)
            S_EXEC: begin
                n_op     = op;
                n_status = op_status;
                n_slot   = i_alloc_slot;
                case (op)
                    OP_INS_EMPTY: begin
                        o_val_req.wr_en      = 1'b1;
                        o_val_req.wr_addr    = i_alloc_slot;
                        o_val_req.wr_data    = r_val;
                        o_free_ctl.alloc_en  = 1'b1;
                        o_free_ctl.alloc_idx = i_alloc_slot;
                        n_head  = i_alloc_slot;
                        n_tail  = i_alloc_slot;
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_INS_FRONT: begin
                        o_val_req.wr_en      = 1'b1;
                        o_val_req.wr_addr    = i_alloc_slot;
                        o_val_req.wr_data    = r_val;
                        o_fwd_req.wr_en      = 1'b1;
                        o_fwd_req.wr_addr    = i_alloc_slot;
                        o_fwd_req.wr_data    = r_head;
                        o_bwd_req.wr_en      = 1'b1;
                        o_bwd_req.wr_addr    = r_head;
                        o_bwd_req.wr_data    = i_alloc_slot;
                        o_free_ctl.alloc_en  = 1'b1;
                        o_free_ctl.alloc_idx = i_alloc_slot;
                        n_head  = i_alloc_slot;
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_INS_BACK: begin
                        o_val_req.wr_en      = 1'b1;
                        o_val_req.wr_addr    = i_alloc_slot;
                        o_val_req.wr_data    = r_val;
                        o_bwd_req.wr_en      = 1'b1;
                        o_bwd_req.wr_addr    = i_alloc_slot;
                        o_bwd_req.wr_data    = r_tail;
                        o_fwd_req.wr_en      = 1'b1;
                        o_fwd_req.wr_addr    = r_tail;
                        o_fwd_req.wr_data    = i_alloc_slot;
                        o_free_ctl.alloc_en  = 1'b1;
                        o_free_ctl.alloc_idx = i_alloc_slot;
                        n_tail  = i_alloc_slot;
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_INS_MID: begin
                        o_fwd_req.rd_en   = 1'b1;
                        o_fwd_req.rd_addr = r_head;
                        n_ptr  = r_head;
                        n_left = CNT_W'(ins_pos - CMP_W'(1));
                    end
                    OP_DEL_ONLY: begin
                        o_free_ctl.release_en  = 1'b1;
                        o_free_ctl.release_idx = r_head;
                        n_head  = '1;
                        n_tail  = '1;
                        n_count = r_count - CNT_W'(1);
                    end
                    OP_DEL_FRONT: begin
                        o_fwd_req.rd_en   = 1'b1;
                        o_fwd_req.rd_addr = r_head;
                        n_ptr  = r_head;
                        n_left = CNT_W'(1);
                    end
                    OP_DEL_BACK: begin
                        o_bwd_req.rd_en   = 1'b1;
                        o_bwd_req.rd_addr = r_tail;
                    end
                    OP_DEL_MID: begin
                        o_fwd_req.rd_en   = 1'b1;
                        o_fwd_req.rd_addr = r_head;
                        n_ptr  = r_head;
                        n_left = CNT_W'(del_pos);
                    end
                    OP_DUMP: begin
                        o_val_req.rd_en   = 1'b1;
                        o_val_req.rd_addr = r_head;
                        o_fwd_req.rd_en   = 1'b1;
                        o_fwd_req.rd_addr = r_head;
                        n_left = r_count;
                    end
                    default: begin
                        n_left = r_left;
                    end
                endcase
            end
            S_WALK: begin
                if (walk_done) begin
                    case (r_op)
                        OP_INS_MID: begin
                            // Link the new slot between the walked node and its successor
                            o_val_req.wr_en   = 1'b1;
                            o_val_req.wr_addr = r_slot;
                            o_val_req.wr_data = r_val;
                            o_fwd_req.wr_en   = 1'b1;
                            o_fwd_req.wr_addr = r_slot;
                            o_fwd_req.wr_data = i_fwd_rd_data;
                            o_bwd_req.wr_en   = 1'b1;
                            o_bwd_req.wr_addr = r_slot;
                            o_bwd_req.wr_data = r_ptr;
                            n_nbr = i_fwd_rd_data;
                        end
                        OP_DEL_FRONT: begin
                            o_free_ctl.release_en  = 1'b1;
                            o_free_ctl.release_idx = r_ptr;
                            n_head  = i_fwd_rd_data;
                            n_count = r_count - CNT_W'(1);
                        end
                        default: begin
                            // Bridge predecessor and successor around the removed node
                            o_fwd_req.wr_en        = 1'b1;
                            o_fwd_req.wr_addr      = r_prev;
                            o_fwd_req.wr_data      = i_fwd_rd_data;
                            o_bwd_req.wr_en        = 1'b1;
                            o_bwd_req.wr_addr      = i_fwd_rd_data;
                            o_bwd_req.wr_data      = r_prev;
                            o_free_ctl.release_en  = 1'b1;
                            o_free_ctl.release_idx = r_ptr;
                            n_count = r_count - CNT_W'(1);
                        end
                    endcase
                end else begin
                    // Advance one link, issuing the next read from the returned link
                    o_fwd_req.rd_en   = 1'b1;
                    o_fwd_req.rd_addr = i_fwd_rd_data;
                    n_prev = r_ptr;
                    n_ptr  = i_fwd_rd_data;
                    n_left = r_left - CNT_W'(1);
                end
            end
            S_FIX: begin
                o_bwd_req.wr_en      = 1'b1;
                o_bwd_req.wr_addr    = r_nbr;
                o_bwd_req.wr_data    = r_slot;
                o_fwd_req.wr_en      = 1'b1;
                o_fwd_req.wr_addr    = r_ptr;
                o_fwd_req.wr_data    = r_slot;
                o_free_ctl.alloc_en  = 1'b1;
                o_free_ctl.alloc_idx = r_slot;
                n_count = r_count + CNT_W'(1);
            end
            S_BACK: begin
                o_free_ctl.release_en  = 1'b1;
                o_free_ctl.release_idx = r_tail;
                n_tail  = i_bwd_rd_data;
                n_count = r_count - CNT_W'(1);
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_status = ST_OK;
                    n_o_total  = TOT_W'(r_count);
                    n_o_value  = i_val_rd_data;
                    n_o_last   = walk_done;
                    if (!walk_done) begin
                        o_val_req.rd_en   = 1'b1;
                        o_val_req.rd_addr = i_fwd_rd_data;
                        o_fwd_req.rd_en   = 1'b1;
                        o_fwd_req.rd_addr = i_fwd_rd_data;
                        n_left = r_left - CNT_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_status = r_status;
                    n_o_total  = TOT_W'(r_count);
                    n_o_value  = '0;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
                n_op = r_op;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '1;
            r_tail      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, walk registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= t_cmd'(i_cmd);
            r_val <= i_item_value;
            r_pos <= i_position;
        end
        r_op       <= n_op;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_ptr      <= n_ptr;
        r_prev     <= n_prev;
        r_nbr      <= n_nbr;
        r_left     <= n_left;
        r_o_status <= n_o_status;
        r_o_total  <= n_o_total;
        r_o_value  <= n_o_value;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_element_total = r_o_total;
    assign o_read_value    = r_o_value;
    assign o_last_item     = r_o_last;

    // Conditions watched by the checks below
    assign walking     = (r_state == S_WALK) || (r_state == S_DUMP);
    assign resp_leave  = (r_state == S_RESP) && out_free;
    assign resp_loaded = r_out_valid && r_o_last && (r_state == S_IDLE);

    `PLE_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `PLE_ASSERT_NOW(a_walk_left, i_clk, i_rst_n, walking, r_left != '0)
    `PLE_ASSERT_NEXT(a_resp_last, i_clk, i_rst_n, resp_leave, resp_loaded)

endmodule

// ===== rtl/positional_list_engine_top.sv =====
`timescale 1ns / 1ps
// Positional list engine: an ordered list of signed 32-bit values in linked slots.
// Request channel (i_in_valid / o_in_ready) carries i_cmd, i_item_value and
// i_position; the result channel (o_out_valid / i_out_ready) carries o_status,
// o_element_total, o_read_value and o_last_item. Every request gives one result
// with o_last_item set, except a dump of a nonempty list, which gives one result
// per element from head to tail and sets o_last_item on the final one.
// Sequence: insert first/last, error and empty-list requests go from S_EXEC to
// S_RESP, which loads the result register; delete last passes through S_BACK,
// delete first through S_WALK, and removing the only element skips both. Inserts
// and deletes in the middle of the list walk the forward link memory one slot per
// cycle in S_WALK. A dump loads its first element and then one element per
// cycle while the receiver does not stall. One request is worked on at a time;
// a new request is taken the cycle after the previous one has left its last
// result in the output register, even while that result still waits. A walk
// near the tail or a dump of a full store holds the engine longest.
// A receiver stall holds the result register and, during a dump, pauses the walk
// without losing an element.
// Reset (synchronous, active low) empties the list and marks every slot free at
// once; no clearing pass is needed, as slot contents are read only after written.
module positional_list_engine_top
    import ple_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [TOT_W-1:0]        o_element_total,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_last_item
);

    t_val_req         val_req;
    t_link_req        fwd_req;
    t_link_req        bwd_req;
    t_free_ctl        free_ctl;
    logic [VAL_W-1:0] val_rd_data;
    logic [IDX_W-1:0] fwd_rd_data;
    logic [IDX_W-1:0] bwd_rd_data;
    logic [IDX_W-1:0] alloc_slot;

    // Sequence requests over the link memories
    ple_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_total (o_element_total),
        .o_read_value    (o_read_value),
        .o_last_item     (o_last_item),
        .o_val_req       (val_req),
        .i_val_rd_data   (val_rd_data),
        .o_fwd_req       (fwd_req),
        .i_fwd_rd_data   (fwd_rd_data),
        .o_bwd_req       (bwd_req),
        .i_bwd_rd_data   (bwd_rd_data),
        .o_free_ctl      (free_ctl),
        .i_alloc_slot    (alloc_slot)
    );

    // Track free slots and offer the lowest one
    ple_free_map u_free_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (free_ctl),
        .o_alloc_slot (alloc_slot)
    );

    // Hold slot values
    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_req.wr_en),
        .i_wr_addr (val_req.wr_addr),
        .i_wr_data (val_req.wr_data),
        .i_rd_en   (val_req.rd_en),
        .i_rd_addr (val_req.rd_addr),
        .o_rd_data (val_rd_data)
    );

    // Hold forward links
    ple_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_fwd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fwd_req.wr_en),
        .i_wr_addr (fwd_req.wr_addr),
        .i_wr_data (fwd_req.wr_data),
        .i_rd_en   (fwd_req.rd_en),
        .i_rd_addr (fwd_req.rd_addr),
        .o_rd_data (fwd_rd_data)
    );

    // Hold backward links
    ple_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_bwd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bwd_req.wr_en),
        .i_wr_addr (bwd_req.wr_addr),
        .i_wr_data (bwd_req.wr_data),
        .i_rd_en   (bwd_req.rd_en),
        .i_rd_addr (bwd_req.rd_addr),
        .o_rd_data (bwd_rd_data)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import ple_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;
    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_RANDOM     = 390;
    localparam int PHASE_LEN      = 40;

    typedef struct packed {
        t_status                 status;
        logic [TOT_W-1:0]        total;
        logic signed [VAL_W-1:0] value;
        logic                    last_item;
    } t_list_result;

    typedef struct packed {
        t_cmd             cmd;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             typed;
        t_status          st;
        logic [TOT_W-1:0] tot;
    } t_dir_row;

    // Directed requests; typed rows carry the single result expected
    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        '{CMD_DUMP,      32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,  7'd0},
        '{CMD_DEL_FIRST, 32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,  7'd0},
        '{CMD_DEL_LAST,  32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,  7'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd1,   1'b1, ST_BADPOS, 7'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd0,   1'b1, ST_BADPOS, 7'd0},
        '{CMD_INS_POS,   32'h0000_0001, 7'd0,   1'b1, ST_BADPOS, 7'd0},
        '{CMD_INS_POS,   32'h0000_0001, 7'd2,   1'b1, ST_BADPOS, 7'd0},
        '{CMD_INS_FIRST, 32'h7FFF_FFFF, 7'd0,   1'b1, ST_OK,     7'd1},
        '{CMD_INS_LAST,  32'h8000_0000, 7'd0,   1'b1, ST_OK,     7'd2},
        '{CMD_INS_POS,   32'h0000_0000, 7'd2,   1'b1, ST_OK,     7'd3},
        '{CMD_INS_POS,   32'hFFFF_FFFF, 7'd4,   1'b1, ST_OK,     7'd4},
        '{CMD_INS_POS,   32'h5555_5555, 7'd1,   1'b1, ST_OK,     7'd5},
        '{CMD_INS_POS,   32'hAAAA_AAAA, 7'd127, 1'b1, ST_BADPOS, 7'd5},
        '{CMD_INS_POS,   32'hAAAA_AAAA, 7'd6,   1'b1, ST_OK,     7'd6},
        '{CMD_DUMP,      32'h0000_0000, 7'd0,   1'b0, ST_OK,     7'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd3,   1'b1, ST_OK,     7'd5},
        '{CMD_INS_POS,   32'h1234_5678, 7'd3,   1'b1, ST_OK,     7'd6},
        '{CMD_DUMP,      32'h0000_0000, 7'd0,   1'b0, ST_OK,     7'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd7,   1'b1, ST_BADPOS, 7'd6},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd127, 1'b1, ST_BADPOS, 7'd6},
        '{CMD_NOP,       32'hDEAD_BEEF, 7'd85,  1'b1, ST_OK,     7'd6},
        '{CMD_DEL_LAST,  32'h0000_0000, 7'd0,   1'b1, ST_OK,     7'd5},
        '{CMD_DEL_POS,   32'h0000_0000, 7'd5,   1'b1, ST_OK,     7'd4},
        '{CMD_DEL_FIRST, 32'h0000_0000, 7'd0,   1'b1, ST_OK,     7'd3},
        '{CMD_DUMP,      32'h0000_0000, 7'd0,   1'b0, ST_OK,     7'd0}
    };

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic [CMD_W-1:0]        i_cmd        = '0;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic [POS_W-1:0]        i_position   = '0;
    logic                    i_out_ready  = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [ST_W-1:0]         o_status;
    logic [TOT_W-1:0]        o_element_total;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_last_item;

    logic signed [VAL_W-1:0] list_vals[$];
    t_list_result            step_results[$];
    t_list_result            pending_results[$];
    int                      mismatches   = 0;
    int                      quiet_cycles = 0;
    bit                      calm         = 1'b0;

    positional_list_engine_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_total (o_element_total),
        .o_read_value    (o_read_value),
        .o_last_item     (o_last_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the list copy and collect the results it causes
    function automatic void model_request(input t_cmd c, input logic signed [VAL_W-1:0] v,
                                          input logic [POS_W-1:0] p);
        int           n;
        int           where;
        t_list_result r;
        n = list_vals.size();
        step_results.delete();
        r = '{status: ST_OK, total: '0, value: '0, last_item: 1'b1};
        case (c) inside
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
                where = (c == CMD_INS_FIRST) ? 1 : (c == CMD_INS_LAST) ? n + 1 : int'(p);
                if (where < 1 || where > n + 1) r.status = ST_BADPOS;
                else if (n >= CAPACITY) r.status = ST_FULL;
                else list_vals.insert(where - 1, v);
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
                where = (c == CMD_DEL_FIRST) ? 1 : (c == CMD_DEL_LAST) ? n : int'(p);
                if (c != CMD_DEL_POS && n == 0) r.status = ST_EMPTY;
                else if (where < 1 || where > n) r.status = ST_BADPOS;
                else list_vals.delete(where - 1);
            end
            CMD_DUMP: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // One result per element, head to tail
                    for (int i = 0; i < n; i++) begin
                        r.total     = TOT_W'(n);
                        r.value     = list_vals[i];
                        r.last_item = (i == n - 1);
                        step_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.total = TOT_W'(list_vals.size());
        step_results.push_back(r);
    endfunction

    // Offer one request, hold it until accepted, then record what it should cause
    task automatic send_request(input t_cmd c, input logic signed [VAL_W-1:0] v,
                                input logic [POS_W-1:0] p, input logic typed = 1'b0,
                                input t_status st = ST_OK, input logic [TOT_W-1:0] tot = '0);
        while (!calm && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= c;
        i_item_value <= v;
        i_position   <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model_request(c, v, p);
        if (typed) begin
            pending_results.push_back(
                t_list_result'{status: st, total: tot, value: '0, last_item: 1'b1});
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Draw a random request; grow_pct steers between inserts and deletes
    task automatic pick_request(input int grow_pct, output t_cmd c,
                                output logic signed [VAL_W-1:0] v, output logic [POS_W-1:0] p);
        int r;
        int n;
        r = $urandom_range(99);
        n = list_vals.size();
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = -32'sd1;
            default: v = $urandom;
        endcase
        p = POS_W'($urandom_range(127, 0));
        if (r < 8) begin
            c = CMD_DUMP;
        end else if (r < 10) begin
            c = CMD_NOP;
        end else if ($urandom_range(99) < grow_pct) begin
            c = t_cmd'(CMD_INS_FIRST + $urandom_range(2, 0));
            if ($urandom_range(99) < 88) p = POS_W'($urandom_range(n + 1, 1));
        end else begin
            c = t_cmd'(CMD_DEL_FIRST + $urandom_range(2, 0));
            if ($urandom_range(99) < 88) p = POS_W'($urandom_range((n == 0) ? 1 : n, 1));
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic check_result();
        t_list_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: st=%0d tot=%0d val=%h",
                                      o_status, o_element_total, o_read_value));
            return;
        end
        want = pending_results.pop_front();
        if (o_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
        if (o_element_total !== want.total)
            report_mismatch($sformatf("element_total %0d, expected %0d",
                                      o_element_total, want.total));
        if (o_read_value !== want.value)
            report_mismatch($sformatf("read_value %h, expected %h", o_read_value, want.value));
        if (o_last_item !== want.last_item)
            report_mismatch($sformatf("last_item %b, expected %b", o_last_item, want.last_item));
    endtask

    // Accept results with random stalls and count cycles with no handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_result();
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
        i_out_ready <= i_rst_n && (calm || $urandom_range(99) >= 6);
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_cmd                    c;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0]        p;
        int                      grow_pct;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].pos,
                         DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].tot);
        end
        drain_results();

        // Fill the store, then hit it with inserts while full and dump it
        while (list_vals.size() < CAPACITY) begin
            pick_request(100, c, v, p);
            send_request(c, v, p);
        end
        send_request(CMD_INS_FIRST, $urandom, 7'd0);
        send_request(CMD_INS_LAST, $urandom, 7'd0);
        send_request(CMD_INS_POS, $urandom, POS_W'($urandom_range(CAPACITY + 1, 1)));
        send_request(CMD_INS_POS, $urandom, 7'd0);
        send_request(CMD_DUMP, '0, 7'd0);

        // Random phases alternating between growing, shrinking and mixed traffic
        for (int k = 0; k < NUM_RANDOM; k++) begin
            calm = (k >= 150 && k < 250);
            if (k == 100 || k == 300) drain_results();
            case ((k / PHASE_LEN) % 3)
                0: grow_pct = 25;
                1: grow_pct = 70;
                default: grow_pct = 50;
            endcase
            pick_request(grow_pct, c, v, p);
            send_request(c, v, p);
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_free_map.sv
rtl/ple_seq.sv
rtl/positional_list_engine_top.sv
verif/tb_top.sv
